/* src/fte_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes of the exact-match forwarding table.
// No dependencies; imported by the core and its checker.
package fte_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DEFAULT = 3'd1,
        ST_NOROUTE = 3'd2,
        ST_DUP     = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic {
        CMD_MAP    = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

    localparam logic [1:0] CFG_DEFAULT_VALID    = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_NEXT_HOP = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_DELAY    = 2'd2;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] hop;
        logic [15:0] dly;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

/* src/fte_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fte_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/forwarding_table_exact_match_core.sv */
`timescale 1ns / 1ps
// Exact-match forwarding table with default route: sequencer, comparator, output register.
// Depends on fte_pkg and fte_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  request  | i_valid / o_ready  | i_command, i_dest_address, i_hop_node, i_link_delay
//  result   | o_valid / i_ready  | o_status, o_next_hop, o_route_delay, o_entry_count
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A request is answered by a linear scan of the table from acceptance to a valid result: one
// comparator reads one stored entry per cycle from the table RAM, a hit stops the scan.
// The next request can be accepted as soon as the result is registered.
// Reset is synchronous and active low; it empties the table and clears the defaults.
// A result waits in the output register; a new request is accepted meanwhile and
// holds in its last cycle until the previous result is taken.
module forwarding_table_exact_match_core import fte_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [15:0] i_dest_address,
    input  logic [15:0] i_hop_node,
    input  logic [15:0] i_link_delay,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_next_hop,
    output logic [15:0] o_route_delay,
    output logic [4:0]  o_entry_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic          r_hit, n_hit;
    logic          r_out_valid, n_out_valid;

    logic          r_def_valid;
    logic [15:0]   r_def_hop;
    logic [15:0]   r_def_dly;

    t_command      r_cmd, n_cmd;
    logic [15:0]   r_addr, n_addr;
    logic [15:0]   r_in_hop, n_in_hop;
    logic [15:0]   r_in_dly, n_in_dly;
    logic [15:0]   r_hop, n_hop;
    logic [15:0]   r_dly, n_dly;
    t_status       r_out_status, n_out_status;
    logic [15:0]   r_out_hop, n_out_hop;
    logic [15:0]   r_out_dly, n_out_dly;
    logic [4:0]    r_out_count, n_out_count;

    logic          w_issue;
    logic          w_cmp_hit;
    logic          w_commit;
    logic          w_we;
    t_entry        w_rd_entry;
    t_entry        w_wr_entry;
    logic [ENTRY_W-1:0] w_rdata;

    fte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (w_wr_entry),
        .i_re    (w_issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd_entry = t_entry'(w_rdata);
    assign w_wr_entry = '{dest: r_addr, hop: r_in_hop, dly: r_in_dly};

    assign w_issue   = (r_state == S_SCAN) && (r_idx < r_fill);
    assign w_cmp_hit = r_pend && (w_rd_entry.dest == r_addr);
    assign w_commit  = (r_state == S_RESP) && (!r_out_valid || i_ready);
    assign w_we      = w_commit && (r_cmd == CMD_MAP) && !r_hit && (r_fill != FULL_COUNT);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_hit        = r_hit;
        n_out_valid  = r_out_valid && !i_ready;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_in_hop     = r_in_hop;
        n_in_dly     = r_in_dly;
        n_hop        = r_hop;
        n_dly        = r_dly;
        n_out_status = r_out_status;
        n_out_hop    = r_out_hop;
        n_out_dly    = r_out_dly;
        n_out_count  = r_out_count;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = t_command'(i_command);
                    n_addr   = i_dest_address;
                    n_in_hop = i_hop_node;
                    n_in_dly = i_link_delay;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (w_cmp_hit) begin
                    n_hit   = 1'b1;
                    n_hop   = w_rd_entry.hop;
                    n_dly   = w_rd_entry.dly;
                    n_pend  = 1'b0;
                    n_state = S_RESP;
                end else if (!w_issue) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_commit) begin
                    n_out_valid = 1'b1;
                    n_out_hop   = '0;
                    n_out_dly   = '0;
                    if (r_cmd == CMD_MAP) begin
                        if (r_hit) begin
                            n_out_status = ST_DUP;
                        end else if (r_fill == FULL_COUNT) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_out_status = ST_OK;
                            n_fill       = r_fill + CW'(1);
                        end
                    end else begin
                        if (r_hit) begin
                            n_out_status = ST_OK;
                            n_out_hop    = r_hop;
                            n_out_dly    = r_dly;
                        end else if (r_def_valid) begin
                            n_out_status = ST_DEFAULT;
                            n_out_hop    = r_def_hop;
                            n_out_dly    = r_def_dly;
                        end else begin
                            n_out_status = ST_NOROUTE;
                        end
                    end
                    n_out_count = 5'(n_fill);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_valid <= 1'b0;
            r_def_hop   <= '0;
            r_def_dly   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEFAULT_VALID:    r_def_valid <= i_cfg_data[0];
                CFG_DEFAULT_NEXT_HOP: r_def_hop   <= i_cfg_data;
                CFG_DEFAULT_DELAY:    r_def_dly   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_addr       <= n_addr;
        r_in_hop     <= n_in_hop;
        r_in_dly     <= n_in_dly;
        r_hop        <= n_hop;
        r_dly        <= n_dly;
        r_out_status <= n_out_status;
        r_out_hop    <= n_out_hop;
        r_out_dly    <= n_out_dly;
        r_out_count  <= n_out_count;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_next_hop    = r_out_hop;
    assign o_route_delay = r_out_dly;
    assign o_entry_count = r_out_count;

endmodule

/* src/fte_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the forwarding table core, attached by bind.
// Depends on fte_pkg and forwarding_table_exact_match_core.
module fte_checker import fte_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [15:0] o_next_hop,
    input logic [15:0] o_route_delay,
    input logic [4:0]  o_entry_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while previous one in flight");

    a_empty_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DUP || o_status == ST_FULL || o_status == ST_NOROUTE))
        |-> (o_next_hop == 16'd0 && o_route_delay == 16'd0))
        else $error("nonzero next hop on a result without a route");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_entry_count == 5'(TABLE_DEPTH)))
        else $error("full status with table not full");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_next_hop)
        && $stable(o_route_delay) && $stable(o_entry_count)))
        else $error("stalled result changed");

endmodule

bind forwarding_table_exact_match_core fte_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_fte_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for forwarding_table_exact_match_core: a directed table of
// map/lookup requests and config writes, then random traffic under several default routes.
// Depends on fte_pkg and the core RTL.
module testbench;
    import fte_pkg::*;

    localparam int TBL_DEPTH   = 16;
    localparam int PHASES      = 6;
    localparam int PHASE_LEN   = 308;
    localparam int CALM_TAIL   = 150;
    localparam int LONG_HOLD   = 120;
    localparam int HOLD_AFTER  = 500;
    localparam int REPORT_CAP  = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 29;

    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        t_status     status;
        logic [15:0] hop;
        logic [15:0] dly;
        logic [4:0]  count;
    } t_route_result;

    typedef struct packed {
        logic          is_cfg;
        t_command      cmd;
        logic [15:0]   addr;
        logic [15:0]   hop;
        logic [15:0]   dly;
        logic [1:0]    reg_idx;
        logic [15:0]   reg_data;
        logic          pinned;
        t_route_result res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [15:0] i_dest_address;
    logic [15:0] i_hop_node;
    logic [15:0] i_link_delay;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [15:0] o_next_hop;
    logic [15:0] o_route_delay;
    logic [4:0]  o_entry_count;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    logic          req_pinned;
    t_route_result req_pinned_res;

    logic [15:0] tbl_dest [TBL_DEPTH];
    logic [15:0] tbl_hop  [TBL_DEPTH];
    logic [15:0] tbl_dly  [TBL_DEPTH];
    int          tbl_fill = 0;
    logic        dflt_on  = 1'b0;
    logic [15:0] dflt_hop = 16'h0000;
    logic [15:0] dflt_dly = 16'h0000;

    t_route_result route_q [$];
    int req_sent    = 0;
    int res_checked = 0;
    int mismatches  = 0;
    int cycles      = 0;
    int n_lookup    = 0;
    int n_hit       = 0;
    int n_default   = 0;
    int n_noroute   = 0;
    int n_dup       = 0;
    int n_full      = 0;
    int n_settings  = 0;
    bit cfg_open       = 1'b0;
    bit calm           = 1'b0;
    bit long_hold_done = 1'b0;

    t_stim_row dir_tbl [DIR_ROWS];

    forwarding_table_exact_match_core #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_dest_address (i_dest_address),
        .i_hop_node     (i_hop_node),
        .i_link_delay   (i_link_delay),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_next_hop     (o_next_hop),
        .o_route_delay  (o_route_delay),
        .o_entry_count  (o_entry_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycles, res_checked, req_sent);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_route_result route_apply(input t_command cmd, input logic [15:0] addr,
                                                  input logic [15:0] hop,
                                                  input logic [15:0] dly);
        t_route_result res;
        int            pos;
        int            k;
        res = '{ST_OK, 16'h0000, 16'h0000, 5'd0};
        pos = -1;
        for (k = 0; k < tbl_fill; k++)
            if (pos < 0 && tbl_dest[k] == addr) pos = k;
        if (cmd == CMD_MAP) begin
            if (pos >= 0) begin
                res.status = ST_DUP;
            end else if (tbl_fill >= TBL_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                tbl_dest[tbl_fill] = addr;
                tbl_hop[tbl_fill]  = hop;
                tbl_dly[tbl_fill]  = dly;
                tbl_fill++;
            end
        end else begin
            if (pos >= 0) begin
                res.hop = tbl_hop[pos];
                res.dly = tbl_dly[pos];
            end else if (dflt_on) begin
                res.status = ST_DEFAULT;
                res.hop    = dflt_hop;
                res.dly    = dflt_dly;
            end else begin
                res.status = ST_NOROUTE;
            end
        end
        res.count = 5'(tbl_fill);
        return res;
    endfunction

    task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : monitor
        t_route_result want;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1 && i_ready) begin
                if (route_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, status %0d hop %h",
                             $time, o_status, o_next_hop);
                end else begin
                    want = route_q.pop_front();
                    res_checked++;
                    case (want.status)
                        ST_OK:      ;
                        ST_DEFAULT: n_default++;
                        ST_NOROUTE: n_noroute++;
                        ST_DUP:     n_dup++;
                        default:    n_full++;
                    endcase
                    if (o_status !== want.status)
                        report("status", 16'(want.status), 16'(o_status));
                    if (o_next_hop !== want.hop)
                        report("next_hop", want.hop, o_next_hop);
                    if (o_route_delay !== want.dly)
                        report("route_delay", want.dly, o_route_delay);
                    if (o_entry_count !== want.count)
                        report("entry_count", 16'(want.count), 16'(o_entry_count));
                end
            end
            if (i_valid && o_ready === 1'b1) begin
                want = route_apply(t_command'(i_command), i_dest_address, i_hop_node,
                                   i_link_delay);
                if (i_command == CMD_LOOKUP) begin
                    n_lookup++;
                    if (want.status == ST_OK) n_hit++;
                end
                route_q.push_back(req_pinned ? req_pinned_res : want);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEFAULT_VALID:    dflt_on  = i_cfg_data[0];
                    CFG_DEFAULT_NEXT_HOP: dflt_hop = i_cfg_data;
                    CFG_DEFAULT_DELAY:    dflt_dly = i_cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    function automatic t_stim_row req_row(input t_command cmd, input logic [15:0] addr,
                                          input logic [15:0] hop, input logic [15:0] dly);
        t_stim_row row;
        row      = '0;
        row.cmd  = cmd;
        row.addr = addr;
        row.hop  = hop;
        row.dly  = dly;
        return row;
    endfunction

    function automatic t_stim_row pin_row(input t_command cmd, input logic [15:0] addr,
                                          input logic [15:0] hop, input logic [15:0] dly,
                                          input t_status st, input logic [15:0] nh,
                                          input logic [15:0] rd, input logic [4:0] cnt);
        t_stim_row row;
        row        = req_row(cmd, addr, hop, dly);
        row.pinned = 1'b1;
        row.res    = '{st, nh, rd, cnt};
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] idx, input logic [15:0] data);
        t_stim_row row;
        row          = '0;
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic t_stim_row random_row();
        logic [15:0] addr;
        bit          hit;
        hit  = ($urandom_range(0, 3) != 0) && (tbl_fill > 0);
        addr = hit ? tbl_dest[$urandom_range(0, tbl_fill - 1)] : 16'($urandom);
        return req_row(t_command'($urandom_range(0, 9) < 7), addr, 16'($urandom),
                       16'($urandom));
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (res_checked < req_sent) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic close_cfg();
        if (cfg_open) i_cfg_we <= 1'b0;
        cfg_open = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        if (!cfg_open) wait_drained();
        cfg_open = 1'b1;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_defaults(input logic on, input logic [15:0] hop, input logic [15:0] dly);
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        write_reg(CFG_DEFAULT_VALID, {15'd0, on});
        write_reg(CFG_DEFAULT_NEXT_HOP, hop);
        write_reg(CFG_DEFAULT_DELAY, dly);
        close_cfg();
        n_settings++;
    endtask

    task automatic send_request(input t_stim_row row);
        close_cfg();
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= row.cmd;
        i_dest_address <= row.addr;
        i_hop_node     <= row.hop;
        i_link_delay   <= row.dly;
        req_pinned     <= row.pinned;
        req_pinned_res <= row.res;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        req_sent++;
    endtask

    initial begin : sink
        i_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (!long_hold_done && res_checked >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int k;
        int ph;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_command      <= CMD_MAP;
        i_dest_address <= 16'h0000;
        i_hop_node     <= 16'h0000;
        i_link_delay   <= 16'h0000;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_DEFAULT_VALID;
        i_cfg_data     <= 16'h0000;
        req_pinned     <= 1'b0;
        req_pinned_res <= '0;

        dir_tbl = '{
            pin_row(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, ST_NOROUTE, 16'h0, 16'h0, 5'd0),
            pin_row(CMD_MAP,    16'h0000, 16'hFFFF, 16'h0000, ST_OK, 16'h0, 16'h0, 5'd1),
            pin_row(CMD_MAP,    16'hFFFF, 16'h0000, 16'hFFFF, ST_OK, 16'h0, 16'h0, 5'd2),
            pin_row(CMD_MAP,    16'h0000, 16'h1111, 16'h2222, ST_DUP, 16'h0, 16'h0, 5'd2),
            pin_row(CMD_LOOKUP, 16'h0000, 16'hABCD, 16'hABCD, ST_OK, 16'hFFFF, 16'h0, 5'd2),
            pin_row(CMD_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, ST_OK, 16'h0, 16'hFFFF, 5'd2),
            pin_row(CMD_LOOKUP, 16'h1234, 16'hFFFF, 16'hFFFF, ST_NOROUTE, 16'h0, 16'h0, 5'd2),
            req_row(CMD_MAP,    16'h0001, 16'h0101, 16'h0010),
            req_row(CMD_MAP,    16'h8000, 16'h8001, 16'h7FFE),
            req_row(CMD_MAP,    16'h00FF, 16'hFF00, 16'h00FF),
            req_row(CMD_MAP,    16'hFF00, 16'h00FF, 16'hFF00),
            req_row(CMD_MAP,    16'h5555, 16'hAAAA, 16'h5555),
            req_row(CMD_MAP,    16'hAAAA, 16'h5555, 16'hAAAA),
            req_row(CMD_MAP,    16'h0F0F, 16'hF0F0, 16'h0F0F),
            req_row(CMD_MAP,    16'hF0F0, 16'h0F0F, 16'hF0F0),
            req_row(CMD_MAP,    16'h3C3C, 16'hC3C3, 16'h0003),
            req_row(CMD_MAP,    16'hC3C3, 16'h3C3C, 16'h0300),
            req_row(CMD_MAP,    16'h1000, 16'h0001, 16'hFFFE),
            req_row(CMD_MAP,    16'h2468, 16'h1357, 16'h9BDF),
            req_row(CMD_MAP,    16'h9BDF, 16'h2468, 16'h1357),
            req_row(CMD_MAP,    16'h7FFF, 16'hBEEF, 16'h0BAD),
            pin_row(CMD_MAP,    16'h7777, 16'h1234, 16'h5678, ST_FULL, 16'h0, 16'h0, 5'd16),
            pin_row(CMD_MAP,    16'h0000, 16'h4321, 16'h8765, ST_DUP, 16'h0, 16'h0, 5'd16),
            cfg_row(CFG_UNUSED_IDX, 16'hFFFF),
            cfg_row(CFG_DEFAULT_VALID, 16'h0001),
            cfg_row(CFG_DEFAULT_NEXT_HOP, 16'hFFFF),
            cfg_row(CFG_DEFAULT_DELAY, 16'hFFFF),
            pin_row(CMD_LOOKUP, 16'h7777, 16'h0, 16'h0, ST_DEFAULT, 16'hFFFF, 16'hFFFF, 5'd16),
            req_row(CMD_LOOKUP, 16'h7FFF, 16'h0000, 16'h0000)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_tbl[k].is_cfg)
                write_reg(dir_tbl[k].reg_idx, dir_tbl[k].reg_data);
            else
                send_request(dir_tbl[k]);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_defaults(1'b0, 16'h0000, 16'h0000);
                1:       set_defaults(1'b1, 16'hFFFF, 16'hFFFF);
                2:       set_defaults(1'b1, 16'h0000, 16'h0000);
                3:       set_defaults(1'b1, 16'($urandom), 16'($urandom));
                4:       set_defaults(1'b0, 16'hFFFF, 16'hFFFF);
                default: set_defaults(1'b1, 16'($urandom), 16'hFFFF);
            endcase
            for (k = 0; k < PHASE_LEN; k++) begin
                if (ph == PHASES - 1 && k >= PHASE_LEN - CALM_TAIL) calm = 1'b1;
                send_request(random_row());
            end
        end

        close_cfg();
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (route_q.size() != 0) begin
            mismatches += route_q.size();
            $display("%0t: %0d results never arrived", $time, route_q.size());
        end

        $display("%0d requests over %0d default-route settings: %0d lookups (%0d hits,",
                 req_sent, n_settings, n_lookup, n_hit);
        $display("  %0d default, %0d no route), %0d duplicate and %0d full maps",
                 n_default, n_noroute, n_dup, n_full);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
